FILE: design/srfp_pkg.sv
// Shared types and constants for the sensor response frame parser.
package srfp_pkg;

	// Largest response frame in bytes, head and checksum included
	localparam int unsigned MAX_RESP = 32;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned LEAD_N  = 4;

	// Register reset values
	localparam logic [BYTE_W-1:0] HEAD_RST = 8'd64;
	localparam logic [BYTE_W-1:0] CMD_RST  = 8'd4;
	localparam logic [BYTE_W-1:0] CAP_RST  = 8'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD_BYTE   = 2'd0,
		REG_EXP_CMD     = 2'd1,
		REG_DATA_CAP    = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_CMD  = 3'd2,
		PH_DATA = 3'd3,
		PH_CHK  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_LEN_REJ  = 2'd1,
		ST_CMD_MISS = 2'd2,
		ST_CSUM_ERR = 2'd3
	} status_t;

endpackage

FILE: design/sensor_response_frame_parser_core.sv
// Sensor response frame parser: byte-wise frame tracking and report generation.
//
// Channel  Dir  Handshake              Payload
// rx       in   rx_valid / rx_ready    rx_byte[7:0]
// res      out  res_valid / res_ready  status[1:0], payload_len[7:0],
//                                      first_word[15:0], second_word[15:0]
// cfg      in   cfg_we (no wait)       cfg_index[1:0], cfg_data[7:0]
//
// One byte per cycle sustained while reports are taken. A byte lands in the
// input register and is worked once it can move on: the frame state updates
// and, at a length reject or the checksum byte, the result register loads.
// Reset clears the frame state to hunting and loads the register defaults. A
// report held by res_ready low blocks the byte in the input register; the
// input takes at most one more byte, then stalls until it leaves.
module sensor_response_frame_parser_core
	import srfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// byte input
	input  logic                 rx_valid,
	output logic                 rx_ready,
	input  logic [BYTE_W-1:0]    rx_byte,
	// report output
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [1:0]           status,
	output logic [BYTE_W-1:0]    payload_len,
	output logic [WORD_W-1:0]    first_word,
	output logic [WORD_W-1:0]    second_word,
	// register writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	localparam int unsigned LEN_W = BYTE_W + 2;
	localparam logic [LEN_W-1:0] MAX_RESP_C = LEN_W'(MAX_RESP);

	// config registers
	logic [BYTE_W-1:0] head_q, exp_cmd_q, cap_q;

	// input register
	logic              rx_valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;

	// frame state
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] frame_len_q, frame_len_d;
	logic [BYTE_W-1:0] left_q, left_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic              cmd_ok_q, cmd_ok_d;
	logic [2:0]        idx_q, idx_d;      // data position, saturates at 4
	logic [BYTE_W-1:0] lead_q [LEAD_N];
	logic [BYTE_W-1:0] lead_d [LEAD_N];

	// result register
	logic              res_valid_q;
	status_t           status_q, status_d;
	logic [BYTE_W-1:0] dlen_q, dlen_d;
	logic [WORD_W-1:0] word0_q, word0_d, word1_q, word1_d;
	logic              res_load;

	logic              advance;
	logic [BYTE_W-1:0] b;
	logic [BYTE_W-1:0] b_m1, flen_m1, left_m1, sum_b;
	logic              len_bad;

	// byte moves out of the input register when the result slot can take it
	assign advance  = rx_valid_s1 && (!res_valid_q || res_ready);
	assign rx_ready = !rx_valid_s1 || advance;

	assign b       = rx_byte_s1;
	assign b_m1    = b - BYTE_W'(1);
	assign flen_m1 = frame_len_q - BYTE_W'(1);
	assign left_m1 = left_q - BYTE_W'(1);
	assign sum_b   = sum_q + b;

	// zero, too long for the frame buffer, or more data than capacity
	assign len_bad = (b == '0) ||
		(({2'b00, b} + LEN_W'(3)) > MAX_RESP_C) ||
		(b_m1 > cap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= HEAD_RST;
			exp_cmd_q <= CMD_RST;
			cap_q     <= CAP_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_HEAD_BYTE: head_q    <= cfg_data;
				REG_EXP_CMD:   exp_cmd_q <= cfg_data;
				REG_DATA_CAP:  cap_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			rx_valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		frame_len_d = frame_len_q;
		left_d      = left_q;
		sum_d       = sum_q;
		cmd_ok_d    = cmd_ok_q;
		idx_d       = idx_q;
		lead_d      = lead_q;
		res_load    = 1'b0;
		status_d    = ST_VALID;
		dlen_d      = flen_m1;
		word0_d     = '0;
		word1_d     = '0;
		unique case (phase_q)
			PH_LEN: begin
				if (len_bad) begin
					phase_d  = PH_HUNT;
					res_load = 1'b1;
					status_d = ST_LEN_REJ;
					dlen_d   = b_m1;
				end else begin
					frame_len_d = b;
					sum_d       = sum_b;
					idx_d       = '0;
					lead_d      = '{default: '0};
					phase_d     = PH_CMD;
				end
			end
			PH_CMD: begin
				cmd_ok_d = (b == exp_cmd_q);
				sum_d    = sum_b;
				left_d   = flen_m1;
				phase_d  = (flen_m1 != '0) ? PH_DATA : PH_CHK;
			end
			PH_DATA: begin
				if (!idx_q[2]) begin
					lead_d[idx_q[1:0]] = b;
					idx_d = idx_q + 3'd1;
				end
				sum_d  = sum_b;
				left_d = left_m1;
				if (left_m1 == '0) phase_d = PH_CHK;
			end
			PH_CHK: begin
				sum_d    = sum_b;
				phase_d  = PH_HUNT;
				res_load = 1'b1;
				if (!cmd_ok_q) begin
					status_d = ST_CMD_MISS;
				end else if (sum_b != '0) begin
					status_d = ST_CSUM_ERR;
				end else begin
					status_d = ST_VALID;
					word0_d  = {lead_q[0], lead_q[1]};
					word1_d  = {lead_q[2], lead_q[3]};
				end
			end
			default: begin
				// hunting; unused codes fall back here
				phase_d = PH_HUNT;
				if (b == head_q) begin
					sum_d   = b;
					phase_d = PH_LEN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else if (advance) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_len_q <= frame_len_d;
			left_q      <= left_d;
			sum_q       <= sum_d;
			cmd_ok_q    <= cmd_ok_d;
			idx_q       <= idx_d;
			lead_q      <= lead_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_load) begin
			status_q <= status_d;
			dlen_q   <= dlen_d;
			word0_q  <= word0_d;
			word1_q  <= word1_d;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign payload_len = dlen_q;
	assign first_word  = word0_q;
	assign second_word = word1_q;

	// an empty result slot never blocks input
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> rx_ready)
		else $error("input stalled with empty result slot");

	// words are only reported for a valid frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && status_q != ST_VALID) |-> (word0_q == '0 && word1_q == '0))
		else $error("words set on a failed frame");

	// a non-head byte while hunting keeps the parser hunting
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_HUNT && rx_byte_s1 != head_q) |=> (phase_q == PH_HUNT))
		else $error("left hunt without head byte");

	// a report is loaded only from the length or checksum byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_load) |-> (phase_q == PH_LEN || phase_q == PH_CHK))
		else $error("report from wrong phase");

endmodule

FILE: dv/tb_sensor_response_frame_parser_core.sv
// Self-checking testbench for sensor_response_frame_parser_core.
module tb_sensor_response_frame_parser_core;
	import srfp_pkg::*;

	// Settling wait in drain: reports pass the input and result registers, plus margin.
	localparam int DRAIN_CYCLES = 6;
	// Cycles with work pending but no handshake before the run is declared hung
	localparam int STALL_LIMIT  = 4000;

	// One report as the parser should produce it
	typedef struct packed {
		status_t           st;
		logic [BYTE_W-1:0] dlen;
		logic [WORD_W-1:0] pm25;
		logic [WORD_W-1:0] pm10;
	} frame_report_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 rx_valid = 1'b0;
	logic                 rx_ready;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic [1:0]           status;
	logic [BYTE_W-1:0]    payload_len;
	logic [WORD_W-1:0]    first_word;
	logic [WORD_W-1:0]    second_word;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;

	sensor_response_frame_parser_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.status      (status),
		.payload_len (payload_len),
		.first_word  (first_word),
		.second_word (second_word),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Bytes waiting to be sent, and reports the parser still owes us
	logic [BYTE_W-1:0] tx_bytes [$];
	frame_report_t     pending_reports [$];

	// Idle percentages and the sender hold used for the pressure pause
	int unsigned snd_idle_pct = 0;
	int unsigned rcv_idle_pct = 0;
	logic        hold_tx = 1'b0;

	// Bookkeeping
	int unsigned err_cnt = 0;
	int unsigned queued_cnt = 0;
	int unsigned rx_cnt = 0;
	int unsigned st_cnt [4] = '{default: 0};
	int unsigned stall_cycles = 0;

	// Register copies kept by the testbench, loaded at every write
	logic [BYTE_W-1:0] cfg_head = HEAD_RST;
	logic [BYTE_W-1:0] cfg_cmd  = CMD_RST;
	logic [BYTE_W-1:0] cfg_cap  = CAP_RST;

	// Frame tracker state, mirrors what the parser keeps
	phase_t                    fp_phase  = PH_HUNT;
	logic [BYTE_W-1:0]         fp_len    = '0;
	logic [BYTE_W-1:0]         fp_left   = '0;
	logic [BYTE_W-1:0]         fp_sum    = '0;
	logic                      fp_cmd_ok = 1'b0;
	logic [3:0][BYTE_W-1:0]    fp_lead   = '0;

	// A length is taken when it is nonzero, the whole frame fits MAX_RESP,
	// and the data part fits the receive buffer.
	function automatic bit len_accepted(input logic [BYTE_W-1:0] len);
		return len != 0 && int'(len) + 3 <= int'(MAX_RESP) &&
			int'(len) - 1 <= int'(cfg_cap);
	endfunction

	// Advance the frame tracker by one accepted byte request; queue the
	// report that this byte causes, if any.
	task automatic parse_byte(input logic [BYTE_W-1:0] b);
		frame_report_t rpt;
		int            pos;
		rpt = '0;
		case (fp_phase)
			PH_LEN: begin
				if (!len_accepted(b)) begin
					// data length wraps, so a zero length reports 255
					fp_phase = PH_HUNT;
					rpt.st   = ST_LEN_REJ;
					rpt.dlen = b - 8'd1;
					pending_reports.push_back(rpt);
				end else begin
					fp_len   = b;
					fp_sum   = fp_sum + b;
					fp_lead  = '0;
					fp_phase = PH_CMD;
				end
			end
			PH_CMD: begin
				fp_cmd_ok = (b == cfg_cmd);
				fp_sum    = fp_sum + b;
				fp_left   = fp_len - 8'd1;
				fp_phase  = (fp_left != 0) ? PH_DATA : PH_CHK;
			end
			PH_DATA: begin
				// only the first four data bytes are kept; the rest just add in
				pos = int'(fp_len - 8'd1) - int'(fp_left);
				if (pos < 4)
					fp_lead[pos] = b;
				fp_sum  = fp_sum + b;
				fp_left = fp_left - 8'd1;
				if (fp_left == 0)
					fp_phase = PH_CHK;
			end
			PH_CHK: begin
				fp_sum   = fp_sum + b;
				fp_phase = PH_HUNT;
				rpt.dlen = fp_len - 8'd1;
				// command mismatch wins over a bad checksum; words only when valid
				if (!fp_cmd_ok)
					rpt.st = ST_CMD_MISS;
				else if (fp_sum != 0)
					rpt.st = ST_CSUM_ERR;
				else begin
					rpt.st   = ST_VALID;
					rpt.pm25 = {fp_lead[0], fp_lead[1]};
					rpt.pm10 = {fp_lead[2], fp_lead[3]};
				end
				pending_reports.push_back(rpt);
			end
			default: begin
				// hunting; a stray phase code falls back here too
				fp_phase = PH_HUNT;
				if (b == cfg_head) begin
					fp_sum   = b;
					fp_phase = PH_LEN;
				end
			end
		endcase
	endtask

	task automatic report_error(input string msg);
		if (err_cnt < 100)
			$display("ERROR at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	// Compare one accepted report with the oldest one owed
	task automatic check_report();
		frame_report_t want;
		if (pending_reports.size() == 0) begin
			report_error($sformatf("report with nothing owed: status %0d dlen %0d",
				status, payload_len));
			return;
		end
		want = pending_reports.pop_front();
		st_cnt[status]++;
		if (status != want.st)
			report_error($sformatf("status %0d, want %0d", status, want.st));
		if (payload_len != want.dlen)
			report_error($sformatf("payload_len %0d, want %0d", payload_len, want.dlen));
		if (first_word != want.pm25)
			report_error($sformatf("first_word %h, want %h", first_word, want.pm25));
		if (second_word != want.pm10)
			report_error($sformatf("second_word %h, want %h", second_word, want.pm10));
	endtask

	// Monitor: track every byte taken and check every report taken, both
	// sampled at the same edge the handshake completes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && rx_ready) begin
				parse_byte(rx_byte);
				rx_cnt++;
			end
			if (res_valid && res_ready)
				check_report();
		end
	end

	// Driver: a new byte request only once the previous one is gone. Valid
	// stays up with the same byte until the parser takes it.
	always @(posedge clk) begin
		if (!arst_n)
			rx_valid <= 1'b0;
		else if (!rx_valid || rx_ready) begin
			if (tx_bytes.size() != 0 && !hold_tx && $urandom_range(99) >= snd_idle_pct) begin
				rx_valid <= 1'b1;
				rx_byte  <= tx_bytes.pop_front();
			end else
				rx_valid <= 1'b0;
		end
	end

	// Receiver stalls at random
	always @(posedge clk)
		res_ready <= arst_n && ($urandom_range(99) >= rcv_idle_pct);

	// Watchdog: only counts while something is outstanding
	always @(posedge clk) begin
		if ((rx_valid && rx_ready) || (res_valid && res_ready) ||
			(tx_bytes.size() == 0 && !rx_valid && pending_reports.size() == 0))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("sensor_response_frame_parser_core test failed");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		tx_bytes.push_back(b);
		queued_cnt++;
	endtask

	// Build one frame with the current head byte. lead gives the first four
	// data bytes (MSB first), later ones are random. A rejected length ends
	// the frame after the length byte. cut >= 0 truncates the frame.
	task automatic send_frame(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] cmd,
		input bit bad_sum, input logic [31:0] lead, input int cut);
		logic [BYTE_W-1:0] frame [$];
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] d;
		int                i;
		frame.push_back(cfg_head);
		frame.push_back(len);
		if (len_accepted(len)) begin
			frame.push_back(cmd);
			for (i = 0; i < int'(len) - 1; i++) begin
				d = (i < 4) ? lead[31 - 8*i -: 8] : 8'($urandom);
				frame.push_back(d);
			end
			sum = '0;
			foreach (frame[k])
				sum = sum + frame[k];
			// a good checksum byte makes the byte total zero mod 256; a bad one misses zero
			if (bad_sum)
				frame.push_back(8'(8'd0 - sum + 8'($urandom_range(255, 1))));
			else
				frame.push_back(8'(8'd0 - sum));
		end
		if (cut >= 0 && cut < frame.size())
			frame = frame[0:cut-1];
		foreach (frame[k])
			push_byte(frame[k]);
	endtask

	// Mostly well-formed frames with random content; some noise, bad
	// lengths, wrong commands, bad checksums and cut-off frames.
	task automatic queue_random_frame();
		int                max_len;
		logic [BYTE_W-1:0] len;
		logic [BYTE_W-1:0] cmd;
		bit                bad;
		int                cut;
		if ($urandom_range(99) < 10)
			repeat ($urandom_range(3, 1))
				push_byte(8'($urandom));
		max_len = (int'(cfg_cap) + 1 < int'(MAX_RESP) - 3) ? int'(cfg_cap) + 1 :
			int'(MAX_RESP) - 3;
		// short frames dominate; an occasional long one
		if ($urandom_range(99) < 80)
			len = ($urandom_range(99) < 85 && max_len > 5) ? 8'($urandom_range(5, 1)) :
				8'($urandom_range(max_len, 1));
		else
			len = 8'($urandom);
		cmd = ($urandom_range(99) < 85) ? cfg_cmd : 8'($urandom);
		bad = ($urandom_range(99) < 15);
		cut = ($urandom_range(99) < 4) ? int'($urandom_range(int'(len) + 2, 2)) : -1;
		send_frame(len, cmd, bad, $urandom, cut);
	endtask

	task automatic fill_random(input int unsigned n);
		int unsigned start;
		start = queued_cnt;
		while (queued_cnt - start < n)
			queue_random_frame();
	endtask

	// Wait until the parser is quiet: every byte sent, every report in
	task automatic drain();
		bit busy;
		busy = 1'b1;
		while (busy) begin
			while (tx_bytes.size() != 0 || rx_valid || pending_reports.size() != 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
			busy = tx_bytes.size() != 0 || rx_valid || pending_reports.size() != 0;
		end
	endtask

	// Register write; only called while the parser is idle
	task automatic write_reg(input reg_idx_t idx, input logic [BYTE_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HEAD_BYTE: cfg_head = val;
			REG_EXP_CMD:   cfg_cmd  = val;
			REG_DATA_CAP:  cfg_cap  = val;
			default: ;
		endcase
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset register values; slow receiver, mildly bursty sender
		snd_idle_pct = 30;
		rcv_idle_pct = 84;
		push_byte(8'h00);                          // dropped while hunting
		push_byte(8'hFF);
		send_frame(8'd0, cfg_cmd, 0, '0, -1);      // zero length
		send_frame(8'd5, cfg_cmd, 0, 32'hFF40_00FF, -1); // head value as data
		send_frame(8'd1, cfg_cmd, 0, '0, -1);      // no data bytes, words zero
		send_frame(8'd6, cfg_cmd, 0, '0, -1);      // over data capacity
		send_frame(8'd3, 8'd5, 1, $urandom, -1);   // wrong command and bad sum
		send_frame(8'd2, cfg_cmd, 1, $urandom, -1); // bad checksum only
		fill_random(140);

		// Hold the sender mid-phase until every owed report is in
		while (tx_bytes.size() > 80)
			@(posedge clk);
		hold_tx <= 1'b1;
		@(posedge clk);
		while (rx_valid || pending_reports.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		hold_tx <= 1'b0;
		drain();

		// Upper extremes: zero head byte, 0xFF command, full buffer
		write_reg(REG_HEAD_BYTE, 8'h00);
		write_reg(REG_EXP_CMD, 8'hFF);
		write_reg(REG_DATA_CAP, 8'hFF);
		snd_idle_pct = 84;
		rcv_idle_pct = 30;
		send_frame(8'(MAX_RESP - 3), cfg_cmd, 0, $urandom, -1); // largest frame
		send_frame(8'(MAX_RESP - 2), cfg_cmd, 0, $urandom, -1); // one too long
		fill_random(150);
		drain();

		// Lower extremes: only a bare command frame fits
		write_reg(REG_HEAD_BYTE, 8'hFF);
		write_reg(REG_EXP_CMD, 8'h00);
		write_reg(REG_DATA_CAP, 8'h00);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		send_frame(8'd1, cfg_cmd, 0, '0, -1);
		send_frame(8'd2, cfg_cmd, 0, '0, -1);
		fill_random(130);
		drain();

		// Random settings, full rate; the spare index must be harmless
		write_reg(REG_UNUSED, 8'($urandom));
		write_reg(REG_HEAD_BYTE, 8'($urandom));
		write_reg(REG_EXP_CMD, 8'($urandom));
		write_reg(REG_DATA_CAP, 8'($urandom_range(MAX_RESP - 4, 0)));
		fill_random(150);
		drain();

		if (pending_reports.size() != 0)
			report_error($sformatf("%0d reports never arrived", pending_reports.size()));
		$display("Sent %0d bytes over four register settings, checked %0d reports:",
			rx_cnt, st_cnt[0] + st_cnt[1] + st_cnt[2] + st_cnt[3]);
		$display("  valid %0d, length rejected %0d, command mismatch %0d, checksum %0d",
			st_cnt[ST_VALID], st_cnt[ST_LEN_REJ], st_cnt[ST_CMD_MISS], st_cnt[ST_CSUM_ERR]);
		if (err_cnt == 0)
			$display("sensor_response_frame_parser_core test passed");
		else
			$display("sensor_response_frame_parser_core test failed");
		$finish;
	end

endmodule

FILE: sim.f
design/srfp_pkg.sv
design/sensor_response_frame_parser_core.sv
dv/tb_sensor_response_frame_parser_core.sv
